FILE: rtl/core/rmst_pkg.sv
// shared widths, codes and types for the range maximum segment tree core
`timescale 1ns / 1ps

package rmst_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 63;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [INDEX_W-1:0] index_t;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

FILE: rtl/core/rmst_mem.sv
// single write port, single registered read port node memory
`timescale 1ns / 1ps

module rmst_mem #(
    parameter int ADDR_W = 11
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  rmst_pkg::value_t      wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output rmst_pkg::value_t      rd_data
);

    rmst_pkg::value_t mem [2**ADDR_W];
    rmst_pkg::value_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/range_max_segment_tree_core.sv
// range maximum segment tree: point set and inclusive range maximum query
// set: the leaf is written when the item is accepted, then one sibling read and one parent write per level
// query: two passes per level over the single node memory read port
// one item at a time; a finished result waits in the output register while the next item enters
// after reset a clearing pass zeroes the node memory, ready stays low
`timescale 1ns / 1ps

module range_max_segment_tree_core #(
    parameter int LEAF_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  rmst_pkg::index_t      s_index,
    input  rmst_pkg::index_t      s_high_index,
    input  rmst_pkg::value_t      s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rmst_pkg::value_t      m_max_value,
    output logic                  m_empty_res
);

    localparam int NW = LEAF_BITS + 1;
    localparam logic [31:0] LEAF_COUNT = 32'd1 << LEAF_BITS;

    typedef logic [NW-1:0] node_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_QRY_A,
        ST_QRY_B,
        ST_QRY_OUT
    } state_t;

    state_t           state_reg, state_next;
    node_t            clr_reg, clr_next;
    node_t            node_a_reg, node_a_next;
    node_t            node_b_reg, node_b_next;
    rmst_pkg::value_t cur_reg, cur_next;
    logic             pend_reg, pend_next;
    logic             empty_reg, empty_next;
    logic             m_valid_reg, m_valid_next;
    rmst_pkg::value_t m_max_reg, m_max_next;
    logic             m_empty_reg, m_empty_next;

    logic             mem_we;
    node_t            mem_waddr;
    rmst_pkg::value_t mem_wdata;
    node_t            mem_raddr;
    rmst_pkg::value_t mem_rdata;

    node_t            leaf_a;
    node_t            leaf_b;
    node_t            parent;
    node_t            b_dec;
    logic             set_ok;
    logic             qry_bad;
    rmst_pkg::value_t best_acc;
    rmst_pkg::value_t set_max;

    rmst_mem #(
        .ADDR_W (NW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign leaf_a   = {1'b1, LEAF_BITS'(s_index)};
    assign leaf_b   = {1'b1, LEAF_BITS'(s_high_index)};
    assign set_ok   = 32'(s_index) < LEAF_COUNT;
    assign qry_bad  = (s_index > s_high_index) || !(32'(s_high_index) < LEAF_COUNT);
    assign parent   = {1'b0, node_a_reg[NW-1:1]};
    assign best_acc = (pend_reg && (mem_rdata > cur_reg)) ? mem_rdata : cur_reg;
    assign set_max  = (mem_rdata > cur_reg) ? mem_rdata : cur_reg;
    assign b_dec    = node_b_reg[0] ? node_b_reg : node_b_reg - node_t'(1);

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_max_value = m_max_reg;
    assign m_empty_res = m_empty_reg;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        node_a_next  = node_a_reg;
        node_b_next  = node_b_reg;
        cur_next     = best_acc;
        pend_next    = 1'b0;
        empty_next   = empty_reg;
        m_valid_next = m_valid_reg;
        m_max_next   = m_max_reg;
        m_empty_next = m_empty_reg;
        mem_we       = 1'b0;
        mem_waddr    = node_a_reg;
        mem_wdata    = '0;
        mem_raddr    = node_a_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + node_t'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == rmst_pkg::OP_SET) begin
                        if (set_ok) begin
                            mem_we      = 1'b1;
                            mem_waddr   = leaf_a;
                            mem_wdata   = s_value;
                            node_a_next = leaf_a;
                            cur_next    = s_value;
                            state_next  = ST_SET_RD;
                        end
                    end else begin
                        cur_next    = '0;
                        node_a_next = leaf_a;
                        node_b_next = leaf_b;
                        empty_next  = qry_bad;
                        state_next  = qry_bad ? ST_QRY_OUT : ST_QRY_A;
                    end
                end
            end
            ST_SET_RD: begin
                // sibling of the node just written
                mem_raddr  = {node_a_reg[NW-1:1], ~node_a_reg[0]};
                state_next = ST_SET_WR;
            end
            ST_SET_WR: begin
                mem_we      = 1'b1;
                mem_waddr   = parent;
                mem_wdata   = set_max;
                cur_next    = set_max;
                node_a_next = parent;
                state_next  = (parent == node_t'(1)) ? ST_IDLE : ST_SET_RD;
            end
            ST_QRY_A: begin
                if (node_a_reg < node_b_reg) begin
                    if (node_a_reg[0]) begin
                        mem_raddr   = node_a_reg;
                        pend_next   = 1'b1;
                        node_a_next = node_a_reg + node_t'(1);
                    end
                    state_next = ST_QRY_B;
                end else begin
                    if (node_a_reg == node_b_reg) begin
                        mem_raddr = node_a_reg;
                        pend_next = 1'b1;
                    end
                    state_next = ST_QRY_OUT;
                end
            end
            ST_QRY_B: begin
                if (!node_b_reg[0]) begin
                    mem_raddr = node_b_reg;
                    pend_next = 1'b1;
                end
                node_b_next = {1'b0, b_dec[NW-1:1]};
                node_a_next = {1'b0, node_a_reg[NW-1:1]};
                state_next  = ST_QRY_A;
            end
            ST_QRY_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_max_next   = best_acc;
                    m_empty_next = empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        node_a_reg  <= node_a_next;
        node_b_reg  <= node_b_next;
        cur_reg     <= cur_next;
        empty_reg   <= empty_next;
        m_max_reg   <= m_max_next;
        m_empty_reg <= m_empty_next;
    end

endmodule

FILE: test/range_max_segment_tree_core_tb.sv
// testbench for range_max_segment_tree_core: self-checking set and range maximum query traffic
`timescale 1ns / 1ps

module range_max_segment_tree_core_tb;

    localparam int LEAF_BITS = 10;
    localparam int unsigned LEAVES = 1 << LEAF_BITS;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * LEAF_BITS + 8;
    localparam rmst_pkg::value_t ALL_ONES = {rmst_pkg::VALUE_W{1'b1}};

    typedef struct {
        rmst_pkg::value_t max_value;
        logic             empty_res;
    } range_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_op = rmst_pkg::OP_SET;
    rmst_pkg::index_t s_index = '0;
    rmst_pkg::index_t s_high_index = '0;
    rmst_pkg::value_t s_value = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    rmst_pkg::value_t m_max_value;
    logic             m_empty_res;

    rmst_pkg::value_t node_max [0:2*LEAVES-1];
    range_result_t    pending_maxima [$];
    int               err_cnt = 0;
    bit               tx_steady = 1'b0;
    bit               rx_steady = 1'b0;
    int               rx_hold = 0;

    range_max_segment_tree_core #(
        .LEAF_BITS(LEAF_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_index(s_index),
        .s_high_index(s_high_index),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_max_value(m_max_value),
        .m_empty_res(m_empty_res)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < 2 * LEAVES; i++) begin
            node_max[i] = '0;
        end
    end

    // tree model
    task automatic tree_set_leaf(rmst_pkg::index_t leaf, rmst_pkg::value_t v);
        int unsigned n;
        if (leaf < LEAVES) begin
            n = LEAVES + leaf;
            node_max[n] = v;
            n = n >> 1;
            while (n > 0) begin
                node_max[n] = (node_max[2*n] > node_max[2*n+1]) ? node_max[2*n]
                                                                : node_max[2*n+1];
                n = n >> 1;
            end
        end
    endtask

    function automatic range_result_t tree_range_max(rmst_pkg::index_t lo,
                                                     rmst_pkg::index_t hi);
        int unsigned   a;
        int unsigned   b;
        range_result_t res;
        res.max_value = '0;
        res.empty_res = 1'b0;
        if (lo > hi || hi >= LEAVES) begin
            res.empty_res = 1'b1;
            return res;
        end
        a = LEAVES + lo;
        b = LEAVES + hi;
        while (a < b) begin
            if (a % 2 == 1) begin
                if (node_max[a] > res.max_value) res.max_value = node_max[a];
                a++;
            end
            if (b % 2 == 0) begin
                if (node_max[b] > res.max_value) res.max_value = node_max[b];
                b--;
            end
            a = a >> 1;
            b = b >> 1;
        end
        if (a == b && node_max[a] > res.max_value) res.max_value = node_max[a];
        return res;
    endfunction

    function automatic int tx_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic rmst_pkg::value_t rand_value();
        rmst_pkg::value_t v;
        case ($urandom_range(0, 5))
            0: v = ALL_ONES;
            1: v = '0;
            2: v = rmst_pkg::value_t'($urandom_range(0, 255));
            3: v = rmst_pkg::value_t'(1) << $urandom_range(0, rmst_pkg::VALUE_W - 1);
            default: v = rmst_pkg::value_t'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    function automatic rmst_pkg::index_t pick_leaf();
        case ($urandom_range(0, 3))
            0: return rmst_pkg::index_t'($urandom_range(0, 15));
            1: return rmst_pkg::index_t'($urandom_range(LEAVES - 16, LEAVES - 1));
            default: return rmst_pkg::index_t'($urandom_range(0, LEAVES - 1));
        endcase
    endfunction

    // drive one item and wait for it to be taken
    task automatic send_item(logic op, rmst_pkg::index_t lo, rmst_pkg::index_t hi,
                             rmst_pkg::value_t v);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_index      <= lo;
        s_high_index <= hi;
        s_value      <= v;
        do @(posedge aclk); while (!s_ready);
        if (op == rmst_pkg::OP_SET) begin
            tree_set_leaf(lo, v);
        end else begin
            pending_maxima.push_back(tree_range_max(lo, hi));
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_maxima.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_item();
        rmst_pkg::index_t lo;
        rmst_pkg::index_t hi;
        int               r;
        int unsigned      d;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_item(rmst_pkg::OP_SET, pick_leaf(), rmst_pkg::index_t'($urandom),
                      rand_value());
        end else if (r < 55) begin
            lo = rmst_pkg::index_t'($urandom_range(1, LEAVES - 1));
            hi = rmst_pkg::index_t'($urandom_range(0, lo - 1));
            send_item(rmst_pkg::OP_QUERY, lo, hi, rmst_pkg::value_t'({$urandom, $urandom}));
        end else begin
            lo = pick_leaf();
            if ($urandom_range(0, 1) == 0) begin
                d = $urandom_range(0, 20);
                hi = (lo + d > LEAVES - 1) ? rmst_pkg::index_t'(LEAVES - 1)
                                           : rmst_pkg::index_t'(lo + d);
            end else begin
                hi = rmst_pkg::index_t'($urandom_range(lo, LEAVES - 1));
            end
            send_item(rmst_pkg::OP_QUERY, lo, hi, rmst_pkg::value_t'({$urandom, $urandom}));
        end
    endtask

    task automatic test_cleared_tree();
        send_item(rmst_pkg::OP_QUERY, 0, rmst_pkg::index_t'(LEAVES - 1), ALL_ONES);
        send_item(rmst_pkg::OP_QUERY, 700, 700, '0);
    endtask

    task automatic test_extremes();
        send_item(rmst_pkg::OP_SET, 0, rmst_pkg::index_t'(LEAVES - 1), ALL_ONES);
        send_item(rmst_pkg::OP_SET, rmst_pkg::index_t'(LEAVES - 1), 0, rmst_pkg::value_t'(1));
        send_item(rmst_pkg::OP_SET, 512, 3,
                  rmst_pkg::value_t'({(rmst_pkg::VALUE_W+1)/2{2'b01}}));
        send_item(rmst_pkg::OP_QUERY, 0, 0, '0);
        send_item(rmst_pkg::OP_QUERY, rmst_pkg::index_t'(LEAVES - 1),
                  rmst_pkg::index_t'(LEAVES - 1), '0);
        send_item(rmst_pkg::OP_QUERY, 1, rmst_pkg::index_t'(LEAVES - 2), '0);
        send_item(rmst_pkg::OP_QUERY, 0, rmst_pkg::index_t'(LEAVES - 1), '0);
        send_item(rmst_pkg::OP_QUERY, 513, rmst_pkg::index_t'(LEAVES - 1), '0);
        send_item(rmst_pkg::OP_QUERY, 1, 511, '0);
        // lowering a leaf must pull the maxima above it back down
        send_item(rmst_pkg::OP_SET, 0, 0, '0);
        send_item(rmst_pkg::OP_QUERY, 0, rmst_pkg::index_t'(LEAVES - 1), '0);
        // empty ranges, then single-leaf and short ranges around the middle leaves
        send_item(rmst_pkg::OP_QUERY, rmst_pkg::index_t'(LEAVES - 1), 0, ALL_ONES);
        send_item(rmst_pkg::OP_QUERY, 1, 0, '0);
        send_item(rmst_pkg::OP_QUERY, 512, 512, ALL_ONES);
        send_item(rmst_pkg::OP_SET, 511, 0,
                  rmst_pkg::value_t'(1) << (rmst_pkg::VALUE_W - 1));
        send_item(rmst_pkg::OP_QUERY, 500, 520, '0);
        send_item(rmst_pkg::OP_QUERY, 511, 511, '0);
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            send_random_item();
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        rx_hold = 400;
        tx_steady = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_item(rmst_pkg::OP_QUERY, pick_leaf(), rmst_pkg::index_t'(LEAVES - 1), '0);
        end
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_steady_stream(int n);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_traffic(n);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_cleared_tree();
        test_extremes();
        test_random_traffic(200);
        test_output_backpressure();
        test_steady_stream(150);
        test_random_traffic(230);
        wait_drained();
        if (err_cnt == 0) begin
            $display("range_max_segment_tree_core_tb: done, clean");
        end else begin
            $display("range_max_segment_tree_core_tb: done, errors");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        int steady;
        int r;
        stall = 0;
        steady = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else if (stall == 0 && steady == 0 && !rx_steady) begin
                r = $urandom_range(0, 99);
                if (r < 3) steady = $urandom_range(30, 150);
                else if (r < 5) stall = $urandom_range(15, 60);
                else if (r < 30) stall = $urandom_range(1, 3);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (steady > 0) steady--;
            end
        end
    end

    always @(posedge aclk) begin
        range_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_maxima.size() == 0) begin
                $error("unexpected result item: max_value %0h, empty_res %0b",
                       m_max_value, m_empty_res);
                err_cnt++;
            end else begin
                exp_res = pending_maxima.pop_front();
                if (m_max_value !== exp_res.max_value) begin
                    $error("max_value: expected %0h, actual %0h", exp_res.max_value, m_max_value);
                    err_cnt++;
                end
                if (m_empty_res !== exp_res.empty_res) begin
                    $error("empty_res: expected %0b, actual %0b", exp_res.empty_res, m_empty_res);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("range_max_segment_tree_core_tb: done, errors");
        $finish;
    end

endmodule
